// ===== hdl/lqhi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lqhi_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 8;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_ILV = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ODD   = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/lqhi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lqhi_ram
    import lqhi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = WORD_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/linear_queue_with_half_interleave_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Linear array queue of signed words with a perfect-shuffle interleave command.
// Input channel: i_in_valid / o_in_stall carry i_cmd and i_value. Output
// channel: o_out_valid / i_out_stall carry o_data, o_status and o_count.
// Every command gives exactly one result, held in an output register.
// Result timing: enqueue, refused commands, an empty interleave and the unused
// code place their result at the accepting edge; a dequeue reads the word
// store, which has one registered read port, and places its result from the
// S_DEQ state; an interleave first copies the queue into the scratch store
// and then writes it back shuffled, one word per cycle per port.
// Throughput: one command per cycle for the commands that finish at the
// accepting edge while the receiver takes results; o_in_stall stays high
// while a dequeue or an interleave is in progress.
// When the receiver stalls, the result holds and o_in_stall rises until the
// result is transferred. Synchronous reset empties the queue and resets the
// head and tail to slot 0; the stores are not cleared.

module linear_queue_with_half_interleave_unit
    import lqhi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_cmd,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [WORD_W-1:0]      o_data,
    output logic [1:0]                    o_status,
    output logic [COUNT_W-1:0]            o_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEQ  = 2'd1;
    localparam logic [1:0] S_CPY  = 2'd2;
    localparam logic [1:0] S_SHF  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_wr_vld, n_wr_vld;
    logic [IDX_W-1:0] r_wr_addr, n_wr_addr;

    logic              r_out_vld, n_out_vld;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic [1:0]        r_out_status, n_out_status;
    logic [CW-1:0]     r_out_count, n_out_count;

    logic              word_we, scr_we;
    logic [IDX_W-1:0]  word_waddr, word_raddr, scr_raddr;
    logic [WORD_W-1:0] word_wdata, word_rdata, scr_rdata;

    logic              out_free;
    logic              accept;
    logic [CW-1:0]     cur_count;
    logic [CW-1:0]     new_count;
    logic [IDX_W-1:0]  half;
    logic [IDX_W-1:0]  pair;
    logic [CW+COUNT_W-1:0] count_ext;

    function automatic logic [CW-1:0] held(input logic e, input logic [IDX_W-1:0] h,
                                           input logic [IDX_W-1:0] t);
        logic [CW-1:0] c;
        c = {1'b0, t} - {1'b0, h} + CW'(1);
        return e ? '0 : c;
    endfunction

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign cur_count  = held(r_empty, r_head, r_tail);
    assign new_count  = held(n_empty, n_head, n_tail);
    assign half       = r_n[CW-1:1];
    assign pair       = r_idx[CW-1:1];

    lqhi_ram #(.DEPTH(DEPTH), .AW(IDX_W), .DW(WORD_W)) u_word (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (word_waddr),
        .i_wdata (word_wdata),
        .i_raddr (word_raddr),
        .o_rdata (word_rdata)
    );

    lqhi_ram #(.DEPTH(DEPTH), .AW(IDX_W), .DW(WORD_W)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (r_wr_addr),
        .i_wdata (word_rdata),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_n          = r_n;
        n_idx        = r_idx;
        n_wr_vld     = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;

        word_we    = 1'b0;
        word_waddr = r_wr_addr;
        word_wdata = scr_rdata;
        word_raddr = r_head;
        scr_we     = 1'b0;
        scr_raddr  = r_idx[0] ? half + pair : pair;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_data   = '0;
                    n_out_status = ST_OK;
                    case (i_cmd)
                        CMD_ENQ: begin
                            if (!r_empty && r_tail == LAST_IDX) begin
                                n_out_status = ST_FULL;
                            end else begin
                                if (r_empty) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b0;
                                end else begin
                                    n_tail = r_tail + IDX_W'(1);
                                end
                                word_we    = 1'b1;
                                word_waddr = n_tail;
                                word_wdata = i_value;
                            end
                            n_out_vld = 1'b1;
                        end
                        CMD_DEQ: begin
                            if (r_empty) begin
                                n_out_data   = '1;
                                n_out_status = ST_EMPTY;
                                n_out_vld    = 1'b1;
                            end else begin
                                // read issued at the head; drop the word from the queue now
                                if (r_head == r_tail) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_head = r_head + IDX_W'(1);
                                end
                                n_state = S_DEQ;
                            end
                        end
                        CMD_ILV: begin
                            if (cur_count[0]) begin
                                n_out_status = ST_ODD;
                                n_out_vld    = 1'b1;
                            end else if (cur_count == '0) begin
                                n_out_vld = 1'b1;
                            end else begin
                                n_n     = cur_count;
                                n_idx   = '0;
                                n_state = S_CPY;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                    n_out_count = new_count;
                end
            end
            S_DEQ: begin
                n_out_vld    = 1'b1;
                n_out_data   = word_rdata;
                n_out_status = ST_OK;
                n_out_count  = cur_count;
                n_state      = S_IDLE;
            end
            S_CPY: begin
                word_raddr = r_head + r_idx[IDX_W-1:0];
                scr_we     = r_wr_vld;
                if (r_idx != r_n) begin
                    n_wr_vld  = 1'b1;
                    n_wr_addr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CW'(1);
                end else begin
                    // last scratch write lands this cycle
                    n_idx   = '0;
                    n_state = S_SHF;
                end
            end
            S_SHF: begin
                word_we = r_wr_vld;
                if (r_idx != r_n) begin
                    n_wr_vld  = 1'b1;
                    n_wr_addr = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_head       = '0;
                    n_tail       = IDX_W'(r_n - CW'(1));
                    n_empty      = 1'b0;
                    n_out_vld    = 1'b1;
                    n_out_data   = '0;
                    n_out_status = ST_OK;
                    n_out_count  = r_n;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
            r_idx     <= '0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_empty   <= n_empty;
            r_idx     <= n_idx;
            r_wr_vld  <= n_wr_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_wr_addr    <= n_wr_addr;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign count_ext   = {{COUNT_W{1'b0}}, r_out_count};
    assign o_out_valid = r_out_vld;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== tb/sv/linear_queue_with_half_interleave_unit_test.sv =====
`timescale 1ns / 1ps

module linear_queue_with_half_interleave_unit_test;
    import lqhi_pkg::*;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t              data;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } queue_result_t;

    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RANDOM_ITEMS = 1500;
    localparam int         REPORT_LIMIT = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_cmd;
    word_t              i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    word_t              o_data;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_count;

    linear_queue_with_half_interleave_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    // Mirror of the queue contents plus the results still owed by the block.
    class shuffle_queue_mirror;
        word_t         held_words[$];
        int unsigned   head_slot;
        queue_result_t owed_results[$];
        int            err_count;

        function new();
            head_slot = 0;
            err_count = 0;
        endfunction

        function int held();
            return held_words.size();
        endfunction

        // Tail sits on the last slot; freed slots below head do not help.
        function bit is_full();
            return held_words.size() != 0 &&
                   head_slot + held_words.size() - 1 == DEPTH_DEF - 1;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void note_command(logic [1:0] cmd, word_t value);
            queue_result_t r;
            word_t         shuffled[$];
            int            half;
            r.data   = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_ENQ: begin
                    if (is_full()) begin
                        r.status = ST_FULL;
                    end else begin
                        if (held_words.size() == 0) head_slot = 0;
                        held_words.push_back(value);
                    end
                end
                CMD_DEQ: begin
                    if (held_words.size() == 0) begin
                        r.data   = -1;
                        r.status = ST_EMPTY;
                    end else begin
                        r.data    = held_words.pop_front();
                        head_slot = (held_words.size() == 0) ? 0 : head_slot + 1;
                    end
                end
                CMD_ILV: begin
                    if (held_words.size() % 2 != 0) begin
                        r.status = ST_ODD;
                    end else if (held_words.size() != 0) begin
                        half = held_words.size() / 2;
                        for (int i = 0; i < half; i++) begin
                            shuffled.push_back(held_words[i]);
                            shuffled.push_back(held_words[half + i]);
                        end
                        held_words = shuffled;
                        head_slot  = 0;
                    end
                end
                default: ;
            endcase
            r.count = COUNT_W'(held_words.size());
            owed_results.push_back(r);
        endfunction

        function void check_result(word_t data, logic [1:0] status, logic [COUNT_W-1:0] count);
            queue_result_t want;
            if (owed_results.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing owed: data %0d status %0d count %0d",
                             $realtime, data, status, count);
                return;
            end
            want = owed_results.pop_front();
            if (data !== want.data || status !== want.status || count !== want.count) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: expected data %0d status %0d count %0d, got %0d %0d %0d",
                             $realtime, want.data, want.status, want.count,
                             data, status, count);
            end
        endfunction
    endclass

    shuffle_queue_mirror queue_mirror = new();

    int items_sent   = 0;
    bit tx_no_gaps   = 1'b0;
    bit hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd(int enq_w, int deq_w, int ilv_w, int spare_w);
        int r;
        r = $urandom_range(0, enq_w + deq_w + ilv_w + spare_w - 1);
        if (r < enq_w) return CMD_ENQ;
        if (r < enq_w + deq_w) return CMD_DEQ;
        if (r < enq_w + deq_w + ilv_w) return CMD_ILV;
        return CMD_SPARE;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(logic [1:0] cmd, word_t value);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            i_cmd      = 2'($urandom);
            i_value    = $urandom;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = cmd;
        i_value    = value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_mirror.note_command(cmd, value);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (queue_mirror.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_mixed(int n);
        int enq_w, deq_w, ilv_w, spare_w;
        enq_w   = $urandom_range(1, 8);
        deq_w   = $urandom_range(1, 8);
        ilv_w   = $urandom_range(0, 2);
        spare_w = $urandom_range(0, 1);
        repeat (n) send_cmd(pick_cmd(enq_w, deq_w, ilv_w, spare_w), pick_word());
    endtask

    task automatic fill_to_full();
        repeat ($urandom_range(0, 4)) send_cmd(CMD_DEQ, pick_word());
        while (!queue_mirror.is_full()) send_cmd(pick_cmd(95, 5, 0, 0), pick_word());
        repeat ($urandom_range(1, 4)) send_cmd(CMD_ENQ, pick_word());
        if ($urandom_range(0, 1) == 0) send_cmd(CMD_ILV, pick_word());
    endtask

    task automatic drain_queue();
        while (queue_mirror.held() != 0) send_cmd(pick_cmd(0, 9, 1, 0), pick_word());
        repeat ($urandom_range(1, 2)) send_cmd(CMD_DEQ, pick_word());
    endtask

    task automatic shuffle_rounds();
        int k;
        repeat ($urandom_range(1, 3)) begin
            k = $urandom_range(1, 12);
            repeat (k) send_cmd(CMD_ENQ, pick_word());
            send_cmd(CMD_ILV, pick_word());
            repeat ($urandom_range(0, k)) send_cmd(CMD_DEQ, pick_word());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            queue_mirror.check_result(o_data, o_status, o_count);
    end

    // Receiver: random stall pattern, with one long hold-off on request.
    initial begin
        int run_left;
        int stall_left;
        run_left    = 0;
        stall_left  = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if (run_left > 0) begin
                i_out_stall = 1'b0;
                run_left--;
            end else begin
                i_out_stall = 1'b0;
                run_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(0, 12);
                stall_left  = pick_gap();
            end
        end
    end

    initial begin
        bit hold_done;
        int directed_items;
        hold_done  = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_ENQ;
        i_value    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty-queue corner cases, extremes, even and odd interleave, drain.
        send_cmd(CMD_DEQ, 32'sh0);
        send_cmd(CMD_ILV, 32'sh0);
        send_cmd(CMD_SPARE, 32'sh7fffffff);
        send_cmd(CMD_ENQ, 32'sh7fffffff);
        send_cmd(CMD_ENQ, 32'sh80000000);
        send_cmd(CMD_ENQ, 32'sh0);
        send_cmd(CMD_ENQ, -32'sh1);
        send_cmd(CMD_ILV, 32'sh0);
        send_cmd(CMD_SPARE, $urandom);
        send_cmd(CMD_ENQ, 32'sh5a5a5a5a);
        send_cmd(CMD_ILV, 32'sh0);
        repeat (5) send_cmd(CMD_DEQ, $urandom);
        send_cmd(CMD_DEQ, 32'sh0);
        send_cmd(CMD_ENQ, 32'sh12345678);
        send_cmd(CMD_DEQ, 32'sh0);
        send_cmd(CMD_ENQ, 32'sha5a5a5a5);
        send_cmd(CMD_ILV, 32'sh0);
        send_cmd(CMD_ENQ, 32'sh0f0f0f0f);
        send_cmd(CMD_ILV, 32'sh0);
        send_cmd(CMD_DEQ, 32'sh0);
        send_cmd(CMD_DEQ, 32'sh0);
        wait_for_results();
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_mixed($urandom_range(20, 60));
                4, 5:       fill_to_full();
                6, 7:       drain_queue();
                8:          shuffle_rounds();
                default:    repeat ($urandom_range(5, 15)) send_cmd(2'($urandom), $urandom);
            endcase
            // Hold off the receiver once while the sender keeps offering.
            if (!hold_done && items_sent >= directed_items + 400) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
                tx_no_gaps   = 1'b1;
                run_mixed(60);
            end
            if ($urandom_range(0, 7) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (300) @(posedge i_clk);
        if (queue_mirror.err_count == 0 && queue_mirror.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
